// ===== rtl/core/cbm_pkg.sv =====
`default_nettype none

package cbm_pkg;

    localparam int ROM_BYTES   = 2097152;
    localparam int RAM_BYTES   = 32768;
    localparam int ROM_AW      = $clog2(ROM_BYTES);
    localparam int RAM_AW      = $clog2(RAM_BYTES);
    localparam int PAGE_W      = 14;                 // 16 KiB ROM bank
    localparam int BANK_W      = ROM_AW - PAGE_W;    // bank bits the ROM can use
    localparam int BANK_FULL_W = 7;                  // 5 low + 2 upper bank bits
    localparam int RAM_FULL_W  = 15;                 // 2 RAM bank bits + 8 KiB page
    localparam int CFG_W       = 22;
    localparam int RAM_SIZE_W  = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_W-1:0]      ROM_SIZE_RST  = CFG_W'(32768);
    localparam logic [RAM_SIZE_W-1:0] RAM_SIZE_RST  = RAM_SIZE_W'(8192);
    localparam logic [BANK_W-1:0]     BANK_MASK_RST = BANK_W'((32768 >> PAGE_W) - 1);
    localparam logic [CFG_W-1:0]      ROM_MULTI_MIN = CFG_W'(32'h8000);
    localparam logic [7:0]            RAM_EN_KEY    = 8'h0A;
    localparam logic [7:0]            OPEN_BUS      = 8'hFF;

    typedef enum logic [2:0] {
        OP_READ_ROM  = 3'd0,
        OP_WRITE_CTL = 3'd1,
        OP_READ_RAM  = 3'd2,
        OP_WRITE_RAM = 3'd3,
        OP_LOAD_ROM  = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROM_SIZE = 2'd0,
        CFG_RAM_SIZE = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_FF,
        SEL_ROM,
        SEL_RAM
    } t_sel;

    typedef struct packed {
        logic [CFG_W-1:0]      rom_limit;
        logic [RAM_SIZE_W-1:0] ram_limit;
        logic [BANK_W-1:0]     bank_mask;
    } t_cfg;

    typedef struct packed {
        t_sel              sel;
        logic              rom_wr;
        logic [ROM_AW-1:0] rom_idx;
        logic              ram_rd;
        logic              ram_wr;
        logic [RAM_AW-1:0] ram_idx;
    } t_access;

endpackage

`default_nettype wire

// ===== rtl/core/cbm_cfg.sv =====
`default_nettype none

module cbm_cfg
    import cbm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [CFG_W-1:0]      r_rom_limit, n_rom_limit;
    logic [RAM_SIZE_W-1:0] r_ram_limit, n_ram_limit;
    logic [BANK_W-1:0]     r_bank_mask, n_bank_mask;
    logic [CFG_W-1:0]      rom_clamp;
    logic [RAM_SIZE_W-1:0] ram_clamp;
    logic [CFG_W-1:0]      bank_count;

    always_comb begin
        rom_clamp = (i_cfg_data > CFG_W'(ROM_BYTES)) ? CFG_W'(ROM_BYTES) : i_cfg_data;
        ram_clamp = (i_cfg_data[RAM_SIZE_W-1:0] > RAM_SIZE_W'(RAM_BYTES)) ?
                    RAM_SIZE_W'(RAM_BYTES) : i_cfg_data[RAM_SIZE_W-1:0];
        bank_count = rom_clamp >> PAGE_W;

        n_rom_limit = r_rom_limit;
        n_ram_limit = r_ram_limit;
        n_bank_mask = r_bank_mask;
        if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ROM_SIZE: begin
                    n_rom_limit = rom_clamp;
                    // below two banks the whole ROM is fixed at bank one
                    n_bank_mask = (rom_clamp >= ROM_MULTI_MIN) ?
                                  BANK_W'(bank_count - CFG_W'(1)) : '0;
                end
                CFG_RAM_SIZE: begin
                    n_ram_limit = ram_clamp;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_limit <= ROM_SIZE_RST;
            r_ram_limit <= RAM_SIZE_RST;
            r_bank_mask <= BANK_MASK_RST;
        end else begin
            r_rom_limit <= n_rom_limit;
            r_ram_limit <= n_ram_limit;
            r_bank_mask <= n_bank_mask;
        end
    end

    assign o_cfg.rom_limit = r_rom_limit;
    assign o_cfg.ram_limit = r_ram_limit;
    assign o_cfg.bank_mask = r_bank_mask;

endmodule

`default_nettype wire

// ===== rtl/core/cbm_ctrl.sv =====
`default_nettype none

module cbm_ctrl
    import cbm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire t_op                  i_op,
    input  wire logic [15:0]          i_address,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [ROM_AW-1:0]    i_load_index,
    input  wire t_cfg                 i_cfg,
    output t_access                   o_acc
);

    typedef enum logic [1:0] {
        REG_RAM_EN,
        REG_LOW_BANK,
        REG_UPPER_BANK,
        REG_MODE
    } t_region;

    logic       r_ram_en;
    logic [4:0] r_low_bank;
    logic [1:0] r_upper_bank;
    logic       r_mode;

    logic [BANK_FULL_W-1:0] bank_full;
    logic [BANK_W-1:0]      sw_bank;
    logic [ROM_AW-1:0]      rom_rd_idx;
    logic                   rom_ok;
    logic [RAM_FULL_W-1:0]  ram_full;
    logic                   ram_ok;

    always_comb begin
        bank_full = {(r_mode ? 2'b00 : r_upper_bank), r_low_bank}
                    & BANK_FULL_W'(i_cfg.bank_mask);
        sw_bank   = bank_full[BANK_W-1:0];
        if (sw_bank == '0) begin
            sw_bank = BANK_W'(1);
        end
        rom_rd_idx = i_address[PAGE_W] ? {sw_bank, i_address[PAGE_W-1:0]}
                                       : ROM_AW'(i_address[PAGE_W-1:0]);
        rom_ok = !i_address[15] && (CFG_W'(rom_rd_idx) < i_cfg.rom_limit);

        ram_full = {(r_mode ? r_upper_bank : 2'b00), i_address[12:0]};
        ram_ok   = r_ram_en && (i_address[15:13] == 3'b101)
                   && (RAM_SIZE_W'(ram_full) < i_cfg.ram_limit);

        o_acc.sel     = SEL_ZERO;
        o_acc.rom_wr  = 1'b0;
        o_acc.rom_idx = rom_rd_idx;
        o_acc.ram_rd  = 1'b0;
        o_acc.ram_wr  = 1'b0;
        o_acc.ram_idx = ram_full[RAM_AW-1:0];
        unique case (i_op)
            OP_READ_ROM: begin
                o_acc.sel = rom_ok ? SEL_ROM : SEL_FF;
            end
            OP_WRITE_CTL: begin
            end
            OP_READ_RAM: begin
                o_acc.sel    = ram_ok ? SEL_RAM : SEL_FF;
                o_acc.ram_rd = ram_ok;
            end
            OP_WRITE_RAM: begin
                o_acc.ram_wr = ram_ok;
            end
            OP_LOAD_ROM: begin
                o_acc.rom_wr  = 1'b1;
                o_acc.rom_idx = i_load_index;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_en     <= 1'b0;
            r_low_bank   <= 5'd1;
            r_upper_bank <= 2'd0;
            r_mode       <= 1'b0;
        end else if (i_fire && (i_op == OP_WRITE_CTL) && !i_address[15]) begin
            unique case (t_region'(i_address[14:13]))
                REG_RAM_EN: begin
                    r_ram_en <= (i_data_byte == RAM_EN_KEY);
                end
                REG_LOW_BANK: begin
                    r_low_bank <= (i_data_byte[4:0] == 5'd0) ? 5'd1 : i_data_byte[4:0];
                end
                REG_UPPER_BANK: begin
                    r_upper_bank <= i_data_byte[1:0];
                end
                REG_MODE: begin
                    r_mode <= i_data_byte[0];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cbm_rom.sv =====
`default_nettype none

module cbm_rom
    import cbm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_wr,
    input  wire logic              i_rd,
    input  wire logic [ROM_AW-1:0] i_idx,
    input  wire logic [7:0]        i_data,
    output logic [7:0]             o_q
);

    logic [7:0] mem [ROM_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_idx] <= i_data;
        end
        if (i_rd) begin
            r_q <= mem[i_idx];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/cbm_ram.sv =====
`default_nettype none

module cbm_ram
    import cbm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic              i_rd,
    input  wire logic [RAM_AW-1:0] i_idx,
    input  wire logic [7:0]        i_data,
    output logic [7:0]             o_q,
    output logic                   o_clearing
);

    logic [7:0]        mem [RAM_BYTES];
    logic [7:0]        r_q;
    logic              r_clearing;
    logic [RAM_AW-1:0] r_clr_addr;

    // zeroing sweep after reset, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + RAM_AW'(1);
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 8'h00;
        end else if (i_wr) begin
            mem[i_idx] <= i_data;
        end
        if (i_rd) begin
            r_q <= mem[i_idx];
        end
    end

    assign o_q        = r_q;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ===== rtl/core/cartridge_bank_mapper_core.sv =====
// channel  | handshake                | payload
// ---------+--------------------------+--------------------------------------------
// request  | i_in_valid / o_in_stall  | i_operation, i_address, i_data_byte,
//          |                          | i_load_index
// result   | o_out_valid / i_out_stall| o_read_data
// config   | i_cfg_wr_en              | i_cfg_index, i_cfg_data
//
// One request per cycle when not stalled; each taken request passes the input register, then
// bank decode and a single memory port access into the result register.
// After reset the RAM is zeroed, one byte a cycle: requests are stalled until all RAM_BYTES
// (32768) bytes are cleared; config writes are taken throughout.
// A stalled result holds the pipe; requests keep flowing while the result register drains.
`default_nettype none

module cartridge_bank_mapper_core
    import cbm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [2:0]           i_operation,
    input  wire logic [15:0]          i_address,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [20:0]          i_load_index,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [7:0]                o_read_data,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic        r_s1_valid;
    t_op         r_s1_op;
    logic [15:0] r_s1_addr;
    logic [7:0]  r_s1_data;
    logic [20:0] r_s1_lidx;
    logic        r_s2_valid;
    t_sel        r_s2_sel;

    t_cfg       cfg;
    t_access    acc;
    logic       clearing;
    logic       s2_ready;
    logic       fire;
    logic       accept;
    logic [7:0] rom_q;
    logic [7:0] ram_q;

    assign s2_ready   = !r_s2_valid || !i_out_stall;
    assign fire       = r_s1_valid && s2_ready;
    assign o_in_stall = clearing || (r_s1_valid && !s2_ready);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_s2_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= t_op'(i_operation);
            r_s1_addr <= i_address;
            r_s1_data <= i_data_byte;
            r_s1_lidx <= i_load_index;
        end
        if (fire) begin
            r_s2_sel <= acc.sel;
        end
    end

    cbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cbm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_op         (r_s1_op),
        .i_address    (r_s1_addr),
        .i_data_byte  (r_s1_data),
        .i_load_index (r_s1_lidx[ROM_AW-1:0]),
        .i_cfg        (cfg),
        .o_acc        (acc)
    );

    cbm_rom u_rom (
        .i_clk  (i_clk),
        .i_wr   (fire && acc.rom_wr),
        .i_rd   (fire && (acc.sel == SEL_ROM)),
        .i_idx  (acc.rom_idx),
        .i_data (r_s1_data),
        .o_q    (rom_q)
    );

    cbm_ram u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (fire && acc.ram_wr),
        .i_rd       (fire && acc.ram_rd),
        .i_idx      (acc.ram_idx),
        .i_data     (r_s1_data),
        .o_q        (ram_q),
        .o_clearing (clearing)
    );

    always_comb begin
        unique case (r_s2_sel)
            SEL_ZERO: o_read_data = 8'h00;
            SEL_FF:   o_read_data = OPEN_BUS;
            SEL_ROM:  o_read_data = rom_q;
            SEL_RAM:  o_read_data = ram_q;
            default:  o_read_data = 8'h00;
        endcase
    end

    assign o_out_valid = r_s2_valid;

endmodule

`default_nettype wire
